// File: rtl/tccq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccq_pkg
// Shared types and constants for the two-color cell quantizer: pixel and
// result transaction structs, cell geometry and color codes.
// ----------------------------------------------------------------------------
package tccq_pkg;

    // Cell geometry (square cells, side in pixels, legal range 2..16)
    localparam int CELL_SIDE   = 8;
    localparam int CELL_PIXELS = CELL_SIDE * CELL_SIDE;
    localparam int IDX_W       = $clog2(CELL_PIXELS);

    // 3-bit color code: green weighs 4, red 2, blue 1
    localparam int COLOR_W   = 3;
    localparam int GREEN_BIT = 2;
    localparam int RED_BIT   = 1;
    localparam int BLUE_BIT  = 0;

    // Number of distinct colors held for the current cell
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    typedef logic [COLOR_W-1:0] t_color;

    // Input transaction: one RGB pixel
    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } t_pixel;

    // Output transaction: one result per pixel
    typedef struct packed {
        logic       pixel_bit;
        logic       pixel_error;
        logic       cell_done;
        logic [7:0] cell_attribute;
        logic       cell_conflict;
    } t_result;

endpackage

// File: rtl/two_color_cell_quantizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_color_cell_quantizer_unit
// Two-color cell quantizer: per-pixel color bit and per-cell attribute byte.
// ----------------------------------------------------------------------------
// Pixels enter in cell order, CELL_SIDE*CELL_SIDE per cell, and each gives
// exactly one result transaction. The block takes one pixel per clock when the
// output side keeps up; a pixel's result passes through the input register,
// then the result register, before it is presented at the output. The cell
// state loop (color match plus slot update) is combinational into the cell
// state registers, which is what sets the one-pixel-per-clock rate. Cell
// attribute and conflict are nonzero only on the result with cell_done set;
// cell state clears after that pixel.
// ----------------------------------------------------------------------------
module two_color_cell_quantizer_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel input channel
    input  logic              i_valid,
    output logic              o_ready,
    input  tccq_pkg::t_pixel  i_pixel,
    // result output channel
    output logic              o_valid,
    input  logic              i_ready,
    output tccq_pkg::t_result o_result
);

    logic              r_in_valid;
    tccq_pkg::t_pixel  r_in_pixel;
    logic              r_out_valid;
    tccq_pkg::t_result r_out_result;

    logic              advance;
    tccq_pkg::t_result result;

    // Input stage moves to the result register when that slot is free
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    tccq_cell_tracker u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_pixel   (r_in_pixel),
        .o_result  (result)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_pixel <= i_pixel;
        end
        if (advance) begin
            r_out_result <= result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_result;

endmodule

// File: rtl/tccq_cell_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccq_cell_tracker
// Per-cell color bookkeeping: reduces a pixel to its 3-bit color, matches it
// against the two stored cell colors, and updates the cell state on advance.
// ----------------------------------------------------------------------------
module tccq_cell_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  tccq_pkg::t_pixel i_pixel,
    output tccq_pkg::t_result o_result
);

    tccq_pkg::t_color                r_first;
    tccq_pkg::t_color                r_second;
    logic [1:0]                      r_seen;
    logic [tccq_pkg::IDX_W-1:0]      r_idx;
    logic                            r_conflict;

    tccq_pkg::t_color                n_first;
    tccq_pkg::t_color                n_second;
    logic [1:0]                      n_seen;
    logic                            n_conflict;

    tccq_pkg::t_color                color;
    logic                            hit_first;
    logic                            hit_second;
    logic                            bit_out;
    logic                            err_out;
    logic                            last_pixel;

    // Color reduction: only zero versus nonzero of each channel counts
    always_comb begin
        color                      = '0;
        color[tccq_pkg::GREEN_BIT] = (i_pixel.green_level != 8'd0);
        color[tccq_pkg::RED_BIT]   = (i_pixel.red_level != 8'd0);
        color[tccq_pkg::BLUE_BIT]  = (i_pixel.blue_level != 8'd0);
    end

    assign hit_first  = (r_seen != tccq_pkg::SEEN_NONE) && (color == r_first);
    assign hit_second = (r_seen == tccq_pkg::SEEN_TWO) && (color == r_second);
    assign last_pixel = (r_idx == tccq_pkg::IDX_W'(tccq_pkg::CELL_PIXELS - 1));

    // Match / allocate a color slot
    always_comb begin
        n_first    = r_first;
        n_second   = r_second;
        n_seen     = r_seen;
        n_conflict = r_conflict;
        bit_out    = 1'b1;
        err_out    = 1'b0;
        if (hit_first) begin
            bit_out = 1'b0;
        end else if (hit_second) begin
            bit_out = 1'b1;
        end else if (r_seen == tccq_pkg::SEEN_NONE) begin
            n_first = color;
            n_seen  = tccq_pkg::SEEN_ONE;
            bit_out = 1'b0;
        end else if (r_seen == tccq_pkg::SEEN_ONE) begin
            n_second = color;
            n_seen   = tccq_pkg::SEEN_TWO;
        end else begin
            // third distinct color: flagged, not stored
            err_out    = 1'b1;
            n_conflict = 1'b1;
        end
    end

    // Result fields; cell summary only on the last pixel
    always_comb begin
        o_result                = '0;
        o_result.pixel_bit      = bit_out;
        o_result.pixel_error    = err_out;
        o_result.cell_done      = last_pixel;
        if (last_pixel) begin
            o_result.cell_attribute = {1'b0, n_second, 1'b0, n_first};
            o_result.cell_conflict  = n_conflict;
        end
    end

    // Cell state; cleared after the last pixel of each cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= '0;
            r_second   <= '0;
            r_seen     <= tccq_pkg::SEEN_NONE;
            r_idx      <= '0;
            r_conflict <= 1'b0;
        end else if (i_advance) begin
            if (last_pixel) begin
                r_first    <= '0;
                r_second   <= '0;
                r_seen     <= tccq_pkg::SEEN_NONE;
                r_idx      <= '0;
                r_conflict <= 1'b0;
            end else begin
                r_first    <= n_first;
                r_second   <= n_second;
                r_seen     <= n_seen;
                r_idx      <= r_idx + 1'b1;
                r_conflict <= n_conflict;
            end
        end
    end

endmodule

// File: tb/two_color_cell_quantizer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_color_cell_quantizer_unit_test
// Self-checking bench for the two-color cell quantizer. Pixels are driven in
// cell order through the valid/ready input channel. A local cell-state model
// predicts one result transaction per accepted pixel. A result process checks
// each output transaction against the oldest prediction, field by field.
// Stimulus is a short directed run of pixels, then random cells built from
// one-color, two-color, conflicting and noisy palettes, under varying idle
// rates on both sides and one long output back-pressure stretch.
// ----------------------------------------------------------------------------
module two_color_cell_quantizer_unit_test;

    localparam int CLK_HALF_NS   = 4;
    localparam int RUN_LIMIT_NS  = 2_000_000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 300;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    tccq_pkg::t_pixel  i_pixel;
    logic              o_valid;
    logic              i_ready;
    tccq_pkg::t_result o_result;

    two_color_cell_quantizer_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_pixel  (i_pixel),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    // Cell state of the local model
    tccq_pkg::t_color   cell_first;
    tccq_pkg::t_color   cell_second;
    logic [1:0]         seen_count;
    int                 cell_index;
    logic               cell_conflict_flag;

    // Predicted results, oldest first
    tccq_pkg::t_result  pending_results[$];
    int                 error_count;

    // Idle rates (percent) and receiver hold-off
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 hold_cycles;

    // Palette used to build random cells
    tccq_pkg::t_color   palette[4];
    int                 palette_size;
    bit                 noisy_cell;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("two_color_cell_quantizer_unit_test: errors");
        $finish;
    end

    function automatic void clear_cell_state();
        cell_first         = '0;
        cell_second        = '0;
        seen_count         = tccq_pkg::SEEN_NONE;
        cell_index         = 0;
        cell_conflict_flag = 1'b0;
    endfunction

    // Model: reduce pixel to a color, update cell state, build the result
    function automatic tccq_pkg::t_result quantize_pixel(input tccq_pkg::t_pixel px);
        tccq_pkg::t_color  shade;
        tccq_pkg::t_result res;
        shade                      = '0;
        shade[tccq_pkg::RED_BIT]   = |px.red_level;
        shade[tccq_pkg::GREEN_BIT] = |px.green_level;
        shade[tccq_pkg::BLUE_BIT]  = |px.blue_level;
        res = '0;
        if (seen_count != tccq_pkg::SEEN_NONE && shade == cell_first) begin
            res.pixel_bit = 1'b0;
        end else if (seen_count == tccq_pkg::SEEN_TWO && shade == cell_second) begin
            res.pixel_bit = 1'b1;
        end else if (seen_count == tccq_pkg::SEEN_NONE) begin
            cell_first = shade;
            seen_count = tccq_pkg::SEEN_ONE;
        end else if (seen_count == tccq_pkg::SEEN_ONE) begin
            cell_second   = shade;
            seen_count    = tccq_pkg::SEEN_TWO;
            res.pixel_bit = 1'b1;
        end else begin
            // third color: flagged, not stored
            res.pixel_bit      = 1'b1;
            res.pixel_error    = 1'b1;
            cell_conflict_flag = 1'b1;
        end
        if (cell_index == tccq_pkg::CELL_PIXELS - 1) begin
            res.cell_done      = 1'b1;
            res.cell_attribute = {1'b0, cell_second, 1'b0, cell_first};
            res.cell_conflict  = cell_conflict_flag;
            clear_cell_state();
        end else begin
            cell_index++;
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Nonzero levels lean toward the extremes now and then
    function automatic logic [7:0] channel_level(input bit on);
        if (!on) return 8'h00;
        case ($urandom_range(9))
            0: return 8'hff;
            1: return 8'h01;
            default: return 8'($urandom_range(255, 1));
        endcase
    endfunction

    function automatic tccq_pkg::t_pixel pixel_of_color(input tccq_pkg::t_color shade);
        tccq_pkg::t_pixel px;
        px.red_level   = channel_level(shade[tccq_pkg::RED_BIT]);
        px.green_level = channel_level(shade[tccq_pkg::GREEN_BIT]);
        px.blue_level  = channel_level(shade[tccq_pkg::BLUE_BIT]);
        return px;
    endfunction

    // Send one pixel transaction; predict its result once accepted
    task automatic send_pixel(input tccq_pkg::t_pixel px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(quantize_pixel(px));
    endtask

    // Stop offering pixels and wait until every predicted result has come
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Result channel: check accepted transactions, then drive ready
    always @(posedge i_clk) begin
        tccq_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0h", $time, o_result);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("pixel_bit", want.pixel_bit, o_result.pixel_bit);
                check_field("pixel_error", want.pixel_error, o_result.pixel_error);
                check_field("cell_done", want.cell_done, o_result.cell_done);
                check_field("cell_attribute", want.cell_attribute, o_result.cell_attribute);
                check_field("cell_conflict", want.cell_conflict, o_result.cell_conflict);
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Pick the color mix for the next cell
    task automatic pick_palette();
        int roll;
        roll = $urandom_range(99);
        noisy_cell = (roll < 15);
        if (roll < 35)      palette_size = 1;
        else if (roll < 85) palette_size = 2;
        else                palette_size = $urandom_range(4, 3);
        foreach (palette[k]) palette[k] = tccq_pkg::t_color'($urandom_range(7));
    endtask

    // Directed pixels: level extremes, all eight colors, third-color errors
    task automatic test_directed_pixels();
        tccq_pkg::t_pixel list[$];
        list = '{
            '{8'h00, 8'h00, 8'h00},   // first pixel takes color 0
            '{8'hff, 8'hff, 8'hff},   // second slot: white
            '{8'h01, 8'h00, 8'h00},   // third colors from here on
            '{8'h00, 8'h01, 8'h00},
            '{8'h00, 8'h00, 8'h01},
            '{8'h80, 8'h00, 8'h00},
            '{8'h00, 8'h80, 8'h00},
            '{8'h00, 8'h00, 8'h80},
            '{8'hff, 8'h00, 8'hff},
            '{8'hff, 8'hff, 8'h00},
            '{8'h00, 8'hff, 8'hff},
            '{8'h00, 8'h00, 8'h00},   // matches first color
            '{8'h01, 8'h01, 8'h01},   // matches second color
            '{8'h80, 8'h40, 8'h01},
            '{8'h55, 8'haa, 8'h7f},
            '{8'haa, 8'h55, 8'hfe},
            '{8'h00, 8'h00, 8'h00},
            '{8'h02, 8'h04, 8'h08},
            '{8'h10, 8'h20, 8'h40}
        };
        foreach (list[k]) send_pixel(list[k]);
    endtask

    // Random cells; a new palette is chosen at each cell boundary
    task automatic test_random_cells(input int n_items, input int s_pct, input int r_pct);
        int               slot;
        tccq_pkg::t_pixel px;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int n = 0; n < n_items; n++) begin
            if (cell_index == 0) pick_palette();
            if (noisy_cell) begin
                px = pixel_of_color(tccq_pkg::t_color'($urandom_range(7)));
            end else begin
                // conflicting cells mostly reuse their first two colors
                if (palette_size > 2 && $urandom_range(9) != 0) slot = $urandom_range(1);
                else slot = $urandom_range(palette_size - 1);
                px = pixel_of_color(palette[slot]);
            end
            send_pixel(px);
        end
    endtask

    // Output held off long enough to fill the block and stall its input
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = LONG_HOLD;
        for (int n = 0; n < 2 * tccq_pkg::CELL_PIXELS; n++) begin
            if (cell_index == 0) pick_palette();
            send_pixel(pixel_of_color(palette[$urandom_range(palette_size - 1)]));
        end
        wait_for_drain();
    endtask

    // Sender waits for every result before going on
    task automatic test_pause_until_drained();
        send_idle_pct = 10;
        recv_idle_pct = 10;
        for (int n = 0; n < 40; n++) begin
            if (cell_index == 0) pick_palette();
            send_pixel(pixel_of_color(palette[$urandom_range(palette_size - 1)]));
        end
        wait_for_drain();
    endtask

    // Test sequence
    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_pixel       <= '0;
        error_count   = 0;
        hold_cycles   = 0;
        send_idle_pct = 27;
        recv_idle_pct = 62;
        noisy_cell    = 1'b1;
        palette_size  = 1;
        foreach (palette[k]) palette[k] = '0;
        clear_cell_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_pixels();
        test_random_cells(620, 27, 62);
        test_pause_until_drained();
        test_random_cells(600, 62, 27);
        test_output_backpressure();
        test_random_cells(550, 0, 0);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("two_color_cell_quantizer_unit_test: clean");
        end else begin
            $display("two_color_cell_quantizer_unit_test: errors");
        end
        $finish;
    end

endmodule
